// ===== rtl/ole_pkg.sv =====
// Package for the ordered list engine: sizes, request and status codes,
// the cell control struct and width helpers. No dependencies.
package ole_pkg;

    // List capacity and derived widths
    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CAP_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 5;
    localparam int CMP_W    = (CAP_W > POS_W) ? CAP_W : POS_W;
    localparam int VAL_W    = 32;
    localparam int FPOS_W   = 4;
    localparam int LEN_W    = 5;

    // Request kinds
    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_SEARCH = 2'd1,
        REQ_DELETE = 2'd2
    } req_t;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_BADPOS   = 3'd2,
        ST_FULL     = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    // Control broadcast to every cell
    typedef struct packed {
        logic             ins_en;
        logic             del_en;
        logic [CAP_W-1:0] slot;
        logic [CAP_W-1:0] count;
        logic [VAL_W-1:0] value;
    } cell_ctrl_t;

    // Fit an entry index into the found position field
    function automatic logic [FPOS_W-1:0] to_fpos(input logic [IDX_W-1:0] idx);
        logic [IDX_W+FPOS_W-1:0] wide;
        wide = {{FPOS_W{1'b0}}, idx};
        return wide[FPOS_W-1:0];
    endfunction

    // Fit an entry count into the list length field
    function automatic logic [LEN_W-1:0] to_len(input logic [CAP_W-1:0] cnt);
        logic [CAP_W+LEN_W-1:0] wide;
        wide = {{LEN_W{1'b0}}, cnt};
        return wide[LEN_W-1:0];
    endfunction

endpackage

// ===== rtl/ole_cell.sv =====
// One list cell: holds a single entry, shifts with its neighbors on
// insert and delete, and compares its entry against the search value.
// Depends on ole_pkg.
module ole_cell
(
    input  logic                          clk,
    input  logic [ole_pkg::IDX_W-1:0]     idx,
    input  ole_pkg::cell_ctrl_t           ctrl,
    input  logic [ole_pkg::VAL_W-1:0]     left_data,
    input  logic [ole_pkg::VAL_W-1:0]     right_data,
    output logic [ole_pkg::VAL_W-1:0]     data,
    output logic                          match
);

    logic [ole_pkg::VAL_W-1:0] data_reg;
    logic [ole_pkg::VAL_W-1:0] data_next;
    logic [ole_pkg::CAP_W-1:0] pos;

    assign pos = ole_pkg::CAP_W'(idx);

    // Pick the next entry: shift up, take the new value, shift down or hold
    always_comb
    begin
        data_next = data_reg;
        if (ctrl.ins_en)
        begin
            if (pos > ctrl.slot)
                data_next = left_data;
            else if (pos == ctrl.slot)
                data_next = ctrl.value;
        end
        else if (ctrl.del_en)
        begin
            if (pos >= ctrl.slot)
                data_next = right_data;
        end
    end

    // Hold the entry
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    // Compare only live entries
    assign match = (pos < ctrl.count) && (data_reg == ctrl.value);
    assign data  = data_reg;

endmodule

// ===== rtl/ordered_list_engine_unit.sv =====
// Top level of the ordered list engine: request decode, the chain of
// list cells, first-match encoding and the result register.
// Depends on ole_pkg and ole_cell.

// The engine keeps an ordered list of up to ole_pkg::CAPACITY signed 32-bit
// values in a chain of cells, one entry per cell, and answers every insert,
// search or delete request with exactly one result. All cells shift or
// compare in parallel, so one request can be accepted every clock while
// the result side keeps up. The cells compare while a request is offered,
// and the accepting edge registers the match vector. Once the result
// register can advance, it loads the first-match encoder output and
// raises m_tvalid. A waiting result does not block the next request
// until both the encoder stage and the result register are full.
// Entries start undefined; reset clears only the entry count and valid
// flags: no clearing pass is needed, the block is ready right after reset.
module ordered_list_engine_unit
(
    input  logic        clk,
    input  logic        rst_n,
    // Request side
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [31:0] item_value, [36:32] list_position, [39:37] zero
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    // Result side
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [2:0] status, [6:3] found_position,
                                   // [11:7] list_length, [15:12] zero
);

    localparam int CAP = ole_pkg::CAPACITY;

    // Request fields
    logic [ole_pkg::VAL_W-1:0] req_value;
    logic [ole_pkg::POS_W-1:0] req_pos;
    logic [1:0]                req_kind;

    assign req_value = s_tdata[31:0];
    assign req_pos   = s_tdata[36:32];
    assign req_kind  = s_tuser;

    // Entry count
    logic [ole_pkg::CAP_W-1:0] cnt_reg;
    logic [ole_pkg::CAP_W-1:0] cnt_next;

    // Encoder stage
    logic                      p_valid_reg;
    logic [CAP-1:0]            p_match_reg;
    logic                      p_search_reg;
    ole_pkg::status_t          p_status_reg;
    logic [ole_pkg::CAP_W-1:0] p_len_reg;

    // Result register
    logic                      o_valid_reg;
    logic [15:0]               o_data_reg;

    logic accept;
    logic out_advance;
    logic p_move;

    assign out_advance = !o_valid_reg || m_tready;
    assign p_move      = p_valid_reg && out_advance;
    assign s_tready    = !p_valid_reg || out_advance;
    assign accept      = s_tvalid && s_tready;

    // Decode the request against the current count
    logic [ole_pkg::CMP_W-1:0] pos_w;
    logic [ole_pkg::CMP_W-1:0] cnt_w;
    logic                      full;
    logic                      empty;
    logic                      pos_out;
    ole_pkg::cell_ctrl_t       ctrl;
    ole_pkg::status_t          req_status;

    assign pos_w   = ole_pkg::CMP_W'(req_pos);
    assign cnt_w   = ole_pkg::CMP_W'(cnt_reg);
    assign full    = (cnt_reg == ole_pkg::CAP_W'(CAP));
    assign empty   = (cnt_reg == '0);
    assign pos_out = (pos_w >= cnt_w);

    always_comb
    begin
        ctrl.ins_en = 1'b0;
        ctrl.del_en = 1'b0;
        ctrl.slot   = pos_out ? cnt_reg : ole_pkg::CAP_W'(pos_w);
        ctrl.count  = cnt_reg;
        ctrl.value  = req_value;
        req_status  = ole_pkg::ST_OK;
        cnt_next    = cnt_reg;
        case (req_kind)
            ole_pkg::REQ_INSERT:
            begin
                if (full)
                    req_status = ole_pkg::ST_FULL;
                else
                begin
                    ctrl.ins_en = accept;
                    cnt_next    = cnt_reg + 1'b1;
                end
            end
            ole_pkg::REQ_SEARCH:
            begin
                req_status = ole_pkg::ST_NOTFOUND;
            end
            ole_pkg::REQ_DELETE:
            begin
                if (empty)
                    req_status = ole_pkg::ST_EMPTY;
                else if (pos_out)
                    req_status = ole_pkg::ST_BADPOS;
                else
                begin
                    ctrl.del_en = accept;
                    cnt_next    = cnt_reg - 1'b1;
                end
            end
            default:
            begin
                req_status = ole_pkg::ST_OK;
            end
        endcase
    end

    // Chain of cells
    logic [ole_pkg::VAL_W-1:0] cell_data [CAP];
    logic [CAP-1:0]            cell_match;

    for (genvar k = 0; k < CAP; k++)
    begin : g_cell
        logic [ole_pkg::VAL_W-1:0] left_in;
        logic [ole_pkg::VAL_W-1:0] right_in;

        if (k == 0)
        begin : g_first
            assign left_in = req_value;
        end
        else
        begin : g_left
            assign left_in = cell_data[k-1];
        end

        if (k == CAP - 1)
        begin : g_last
            assign right_in = '0;
        end
        else
        begin : g_right
            assign right_in = cell_data[k+1];
        end

        ole_cell u_cell
        (
            .clk        (clk),
            .idx        (ole_pkg::IDX_W'(k)),
            .ctrl       (ctrl),
            .left_data  (left_in),
            .right_data (right_in),
            .data       (cell_data[k]),
            .match      (cell_match[k])
        );
    end

    // Update count and load the encoder stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            p_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                cnt_reg     <= cnt_next;
                p_valid_reg <= 1'b1;
            end
            else if (p_move)
            begin
                p_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p_match_reg  <= cell_match;
            p_search_reg <= (req_kind == ole_pkg::REQ_SEARCH);
            p_status_reg <= req_status;
            p_len_reg    <= cnt_next;
        end
    end

    // Encode the first match
    logic [ole_pkg::IDX_W-1:0] first_idx;
    logic                      any_match;
    ole_pkg::status_t          res_status;
    logic [ole_pkg::FPOS_W-1:0] res_fpos;

    always_comb
    begin
        first_idx = '0;
        for (int k = CAP - 1; k >= 0; k--)
        begin
            if (p_match_reg[k])
                first_idx = ole_pkg::IDX_W'(k);
        end
    end

    assign any_match  = |p_match_reg;
    assign res_status = (p_search_reg && any_match) ? ole_pkg::ST_OK : p_status_reg;
    assign res_fpos   = (p_search_reg && any_match) ? ole_pkg::to_fpos(first_idx) : '0;

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_valid_reg <= 1'b0;
        else if (out_advance)
            o_valid_reg <= p_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (p_move)
            o_data_reg <= {4'b0000, ole_pkg::to_len(p_len_reg), res_fpos, res_status};
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = o_data_reg;

endmodule

// ===== test/ordered_list_engine_unit_check.sv =====
// Checker for the ordered list engine: watches the request and result channels,
// keeps its own copy of the list to predict each result, and counts mismatches.
// Depends on ole_pkg.
module ordered_list_engine_unit_check
    import ole_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,      // [31:0] item_value, [36:32] list_position
    input  logic [1:0]  s_tuser,      // [1:0] req_type
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,      // [2:0] status, [6:3] found_position, [11:7] list_length
    output int          fail_count,
    output int          results_due
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        status_t           status;
        logic [FPOS_W-1:0] found_pos;
        logic [LEN_W-1:0]  length;
    } list_result_t;

    // Shadow copy of the list
    logic [VAL_W-1:0] shadow_vals [CAPACITY];
    int               shadow_len;
    list_result_t     pending_results [$];

    initial
    begin
        fail_count  = 0;
        results_due = 0;
        shadow_len  = 0;
    end

    // Apply one request to the shadow list and return the result it should give
    function automatic list_result_t apply_request(input logic [1:0] kind,
                                                   input logic [VAL_W-1:0] val,
                                                   input logic [POS_W-1:0] pos);
        list_result_t res;
        int           slot;
        res.status    = ST_OK;
        res.found_pos = '0;
        case (kind)
            REQ_INSERT:
            begin
                if (shadow_len >= CAPACITY)
                    res.status = ST_FULL;
                else
                begin
                    slot = (int'(pos) < shadow_len) ? int'(pos) : shadow_len;
                    for (int k = shadow_len; k > slot; k--)
                        shadow_vals[k] = shadow_vals[k-1];
                    shadow_vals[slot] = val;
                    shadow_len++;
                end
            end
            REQ_SEARCH:
            begin
                res.status = ST_NOTFOUND;
                for (int k = 0; k < shadow_len; k++)
                begin
                    if (shadow_vals[k] === val)
                    begin
                        res.status    = ST_OK;
                        res.found_pos = k[FPOS_W-1:0];
                        break;
                    end
                end
            end
            REQ_DELETE:
            begin
                if (shadow_len == 0)
                    res.status = ST_EMPTY;
                else if (int'(pos) >= shadow_len)
                    res.status = ST_BADPOS;
                else
                begin
                    for (int k = int'(pos); k + 1 < shadow_len; k++)
                        shadow_vals[k] = shadow_vals[k+1];
                    shadow_len--;
                end
            end
            default: ;  // unused request kind leaves the list alone
        endcase
        res.length = shadow_len[LEN_W-1:0];
        return res;
    endfunction

    // Compare results against the oldest prediction, then record new requests
    always @(posedge clk)
    begin : watch
        list_result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (m_tdata[2:0] !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, m_tdata[2:0]);
                        fail_count++;
                    end
                    if (m_tdata[6:3] !== want.found_pos)
                    begin
                        $display("%0t: found_position expected %0d actual %0d",
                                 $time, want.found_pos, m_tdata[6:3]);
                        fail_count++;
                    end
                    if (m_tdata[11:7] !== want.length)
                    begin
                        $display("%0t: list_length expected %0d actual %0d",
                                 $time, want.length, m_tdata[11:7]);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                pending_results.push_back(apply_request(s_tuser, s_tdata[31:0],
                                                        s_tdata[36:32]));
            results_due = pending_results.size();
        end
    end

endmodule

// ===== test/ordered_list_engine_unit_test.sv =====
// Testbench top for the ordered list engine: clock, reset, request stimulus
// and result back-pressure, with the verdict taken from the checker.
// Depends on ole_pkg, ordered_list_engine_unit and ordered_list_engine_unit_check.
module ordered_list_engine_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    import ole_pkg::*;

    localparam logic [1:0] REQ_UNUSED  = 2'd3;
    localparam int         CYCLE_LIMIT = 200000;
    localparam int         PHASE_ITEMS = 325;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    int fail_count;
    int results_due;
    int idle_pct  = 0;
    int stall_pct = 0;
    int cycles    = 0;

    always #5 clk = ~clk;

    ordered_list_engine_unit i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    ordered_list_engine_unit_check i_check
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .results_due (results_due)
    );

    // Stall the result side at random
    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= stall_pct);

    // Stop a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Offer one request, idling first at random, and hold it until taken
    task automatic send_request(input logic [1:0] kind, input logic [31:0] val,
                                input logic [4:0] pos);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {3'b000, pos, val};
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    // Values that repeat often, so searches hit and duplicates occur
    function automatic logic [31:0] pool_value(input int idx);
        case (idx)
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            4:       return 32'h0000_0001;
            5:       return 32'h5555_5555;
            6:       return 32'hAAAA_AAAA;
            default: return 32'h1234_5678;
        endcase
    endfunction

    initial
    begin : stimulus
        int          roll;
        int          bias;
        logic [1:0]  kind;
        logic [31:0] val;
        logic [4:0]  pos;

        // Hold reset, then release between edges
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty list corner cases
        send_request(REQ_SEARCH, 32'h0000_0000, 5'd0);
        send_request(REQ_DELETE, 32'hFFFF_FFFF, 5'd0);
        send_request(REQ_UNUSED, 32'h1234_5678, 5'd7);

        // Insert at front, append past end, insert in the middle
        send_request(REQ_INSERT, 32'h8000_0000, 5'd0);
        send_request(REQ_INSERT, 32'h7FFF_FFFF, 5'd31);
        send_request(REQ_INSERT, 32'h0000_0000, 5'd1);
        send_request(REQ_INSERT, 32'hFFFF_FFFF, 5'd16);

        // Search hits and a miss
        send_request(REQ_SEARCH, 32'h7FFF_FFFF, 5'd0);
        send_request(REQ_SEARCH, 32'hFFFF_FFFF, 5'd31);
        send_request(REQ_SEARCH, 32'h0000_0001, 5'd0);

        // Delete out of range, then a valid delete at the front
        send_request(REQ_DELETE, 32'h0, 5'd31);
        send_request(REQ_DELETE, 32'h0, 5'd4);
        send_request(REQ_DELETE, 32'h0, 5'd0);

        // Fill the list, then insert into a full list and delete the tail
        for (int k = 0; k < 13; k++)
            send_request(REQ_INSERT, pool_value(k % 8) ^ k, 5'(k % 5));
        send_request(REQ_INSERT, 32'hDEAD_BEEF, 5'd2);
        send_request(REQ_DELETE, 32'h0, 5'd15);

        // Random requests across phases of idling and result stalls
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 56; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 56; end
                default: begin idle_pct = 13; stall_pct = 13; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // Shift the mix every 40 requests so the list fills and drains
                bias = ((phase * PHASE_ITEMS + n) / 40) % 3;
                roll = $urandom_range(99);
                if (roll < 2)
                    kind = REQ_UNUSED;
                else if (bias == 0)
                    kind = (roll < 60) ? REQ_INSERT : (roll < 82) ? REQ_SEARCH : REQ_DELETE;
                else if (bias == 1)
                    kind = (roll < 20) ? REQ_INSERT : (roll < 42) ? REQ_SEARCH : REQ_DELETE;
                else
                    kind = (roll < 40) ? REQ_INSERT : (roll < 70) ? REQ_SEARCH : REQ_DELETE;
                val = ($urandom_range(99) < 60) ? pool_value($urandom_range(7)) : $urandom;
                pos = ($urandom_range(99) < 20) ? 5'($urandom_range(31))
                                                : 5'($urandom_range(17));
                send_request(kind, val, pos);
            end
        end
        s_tvalid <= 1'b0;

        // Drain outstanding results, then watch for stray ones
        idle_pct = 0;
        while (results_due != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);

        if (fail_count == 0 && results_due == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/ole_pkg.sv
rtl/ole_cell.sv
rtl/ordered_list_engine_unit.sv
test/ordered_list_engine_unit_check.sv
test/ordered_list_engine_unit_test.sv
